// ===== sv/kbrce_pkg.sv =====
`default_nettype none

package kbrce_pkg;

    // Request forms
    localparam logic REQ_BOOT     = 1'b0;
    localparam logic REQ_ROLLOVER = 1'b1;

    localparam int BOOT_KEYS    = 6;
    localparam int CARRIED_BITS = 128;
    localparam int BIT_IDX_W    = $clog2(CARRIED_BITS);
    localparam int SLOT_W       = 3;
    localparam int QUEUE_DEPTH  = 2;

    typedef enum logic [1:0] {
        FRONT_IDLE,
        FRONT_SCAN,
        FRONT_PUSH
    } front_state_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

`default_nettype wire

// ===== sv/keyboard_report_change_emitter.sv =====
// Keyboard report change emitter.
// Input channel (in_valid / in_stall): one request is one keyboard report, boot form
// (req_type 0: modifier plus key_a..key_f) or rollover form (req_type 1: modifier plus
// a 128-bit bitmap in bitmap_low / bitmap_high; the lowest KEY_SLOTS set bits become
// keycodes, bit n giving keycode n, unused slots zero).
// Output channel (out_valid / out_stall): when the report differs from the last one
// forwarded, 1 + KEY_SLOTS requests go out: slot 0 the modifier, then the keycodes,
// last set on the final one. Unchanged reports produce nothing.
// Flow: a boot request goes straight to the push state; a rollover request first passes
// the scan state, where the bitmap scanner finds the keys one at a time. The front takes
// no new request until it is idle again. The back emits one word per cycle while
// out_stall is low and the queue holds a report. A two-entry report queue lets the
// front keep accepting while the back drains.
// Reset: remembered report is all zero, queue and output register empty.
// A stalled receiver holds the output word; while the queue is full, the front holds
// a changed pending report. in_stall is high whenever the front is not idle.
`default_nettype none

module keyboard_report_change_emitter
    import kbrce_pkg::*;
#(
    parameter int KEY_SLOTS    = 6,
    parameter int BITMAP_BYTES = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        req_type,
    input  wire logic [7:0]  modifier,
    input  wire logic [7:0]  key_a,
    input  wire logic [7:0]  key_b,
    input  wire logic [7:0]  key_c,
    input  wire logic [7:0]  key_d,
    input  wire logic [7:0]  key_e,
    input  wire logic [7:0]  key_f,
    input  wire logic [63:0] bitmap_low,
    input  wire logic [63:0] bitmap_high,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       slot,
    output logic [7:0]       value,
    output logic             last
);

    localparam int REPORT_W = (KEY_SLOTS + 1) * 8;

    logic [BOOT_KEYS-1:0][7:0]   boot_keys;
    logic [CARRIED_BITS-1:0]     bitmap;
    q_status_t                   q_status;
    logic                        q_push;
    logic                        q_pop;
    logic [REPORT_W-1:0]         q_in;
    logic [REPORT_W-1:0]         q_head;

    assign boot_keys = {key_f, key_e, key_d, key_c, key_b, key_a};
    assign bitmap    = {bitmap_high, bitmap_low};

    // front: takes requests, scans the bitmap, filters unchanged reports
    kbrce_front #(
        .KEY_SLOTS    (KEY_SLOTS),
        .BITMAP_BYTES (BITMAP_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .modifier  (modifier),
        .boot_keys (boot_keys),
        .bitmap    (bitmap),
        .q_status  (q_status),
        .push      (q_push),
        .push_data (q_in)
    );

    kbrce_queue #(
        .WIDTH (REPORT_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .status    (q_status)
    );

    // back: serializes one queued report into slot words
    kbrce_back #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .q_status  (q_status),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .slot      (slot),
        .value     (value),
        .last      (last)
    );

endmodule

`default_nettype wire

// ===== sv/kbrce_queue.sv =====
`default_nettype none

module kbrce_queue
    import kbrce_pkg::*;
#(
    parameter int WIDTH = 56
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] head,
    output q_status_t             status
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [QUEUE_DEPTH-1:0][WIDTH-1:0] entry_reg;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign status.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== sv/kbrce_front.sv =====
`default_nettype none

module kbrce_front
    import kbrce_pkg::*;
#(
    parameter int KEY_SLOTS    = 6,
    parameter int BITMAP_BYTES = 16
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic                             req_type,
    input  wire logic [7:0]                       modifier,
    input  wire logic [BOOT_KEYS-1:0][7:0]        boot_keys,
    input  wire logic [CARRIED_BITS-1:0]          bitmap,
    input  wire q_status_t                        q_status,
    output logic                                  push,
    output logic      [(KEY_SLOTS+1)*8-1:0]       push_data
);

    localparam int SCAN_BITS = (BITMAP_BYTES * 8 > CARRIED_BITS) ? CARRIED_BITS
                                                                  : BITMAP_BYTES * 8;
    localparam logic [CARRIED_BITS-1:0] SCAN_MASK =
        (SCAN_BITS == CARRIED_BITS) ? {CARRIED_BITS{1'b1}}
                                    : ((CARRIED_BITS'(1) << SCAN_BITS) - CARRIED_BITS'(1));
    localparam int CNT_W = $clog2(KEY_SLOTS + 1);

    front_state_t                  state_reg, state_next;
    logic [7:0]                    mod_reg, mod_next;
    logic [KEY_SLOTS-1:0][7:0]     keys_reg, keys_next;
    logic [CARRIED_BITS-1:0]       bits_reg, bits_next;
    logic [CNT_W-1:0]              filled_reg, filled_next;
    logic [KEY_SLOTS:0][7:0]       prev_reg, prev_next;
    logic [KEY_SLOTS:0][7:0]       report;
    logic [CARRIED_BITS-1:0]       lowest;
    logic [BIT_IDX_W-1:0]          low_idx;
    logic                          accept;

    assign in_stall  = (state_reg != FRONT_IDLE);
    assign accept    = in_valid && !in_stall;
    assign report    = {keys_reg, mod_reg};
    assign push_data = report;

    // isolate the lowest set bit, then encode its position
    assign lowest = bits_reg & (~bits_reg + CARRIED_BITS'(1));

    always_comb
    begin
        low_idx = '0;
        for (int b = 0; b < CARRIED_BITS; b++)
        begin
            if (lowest[b])
            begin
                low_idx = low_idx | BIT_IDX_W'(b);
            end
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        mod_next    = mod_reg;
        keys_next   = keys_reg;
        bits_next   = bits_reg;
        filled_next = filled_reg;
        prev_next   = prev_reg;
        push        = 1'b0;

        unique case (state_reg)
            FRONT_IDLE:
            begin
                if (accept)
                begin
                    mod_next    = modifier;
                    filled_next = '0;
                    bits_next   = bitmap & SCAN_MASK;
                    for (int i = 0; i < KEY_SLOTS; i++)
                    begin
                        keys_next[i] = '0;
                        if (req_type == REQ_BOOT && i < BOOT_KEYS)
                        begin
                            keys_next[i] = boot_keys[i % BOOT_KEYS];
                        end
                    end
                    state_next = (req_type == REQ_ROLLOVER) ? FRONT_SCAN : FRONT_PUSH;
                end
            end
            FRONT_SCAN:
            begin
                if (bits_reg == '0 || filled_reg == CNT_W'(KEY_SLOTS))
                begin
                    state_next = FRONT_PUSH;
                end
                else
                begin
                    for (int i = 0; i < KEY_SLOTS; i++)
                    begin
                        if (filled_reg == CNT_W'(i))
                        begin
                            keys_next[i] = 8'(low_idx);
                        end
                    end
                    bits_next   = bits_reg & ~lowest;
                    filled_next = filled_reg + CNT_W'(1);
                end
            end
            FRONT_PUSH:
            begin
                if (report == prev_reg)
                begin
                    state_next = FRONT_IDLE;
                end
                else if (!q_status.full)
                begin
                    push       = 1'b1;
                    prev_next  = report;
                    state_next = FRONT_IDLE;
                end
            end
            default:
            begin
                state_next = FRONT_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FRONT_IDLE;
            prev_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            prev_reg  <= prev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mod_reg    <= mod_next;
        keys_reg   <= keys_next;
        bits_reg   <= bits_next;
        filled_reg <= filled_next;
    end

endmodule

`default_nettype wire

// ===== sv/kbrce_back.sv =====
`default_nettype none

module kbrce_back
    import kbrce_pkg::*;
#(
    parameter int KEY_SLOTS = 6
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [KEY_SLOTS:0][7:0]     head,
    input  wire q_status_t                   q_status,
    output logic                             pop,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic      [SLOT_W-1:0]           slot,
    output logic      [7:0]                  value,
    output logic                             last
);

    localparam int CNT_W = $clog2(KEY_SLOTS + 1);

    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              out_valid_reg, out_valid_next;
    logic [SLOT_W-1:0] slot_reg;
    logic [7:0]        value_reg;
    logic              last_reg;
    logic              load;
    logic              at_end;

    assign load      = !q_status.empty && (!out_valid_reg || !out_stall);
    assign at_end    = (idx_reg == CNT_W'(KEY_SLOTS));
    assign pop       = load && at_end;
    assign out_valid = out_valid_reg;
    assign slot      = slot_reg;
    assign value     = value_reg;
    assign last      = last_reg;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            idx_next       = at_end ? '0 : idx_reg + CNT_W'(1);
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slot_reg  <= SLOT_W'(idx_reg);
            value_reg <= head[idx_reg];
            last_reg  <= at_end;
        end
    end

endmodule

`default_nettype wire
